// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check, held off while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/stl_pkg.sv
package stl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_STR,
    MODE_SYM,
    MODE_DROP
  } mode_t;

  localparam logic [2:0] KIND_NUM   = 3'd0;
  localparam logic [2:0] KIND_IDENT = 3'd1;
  localparam logic [2:0] KIND_STR   = 3'd2;
  localparam logic [2:0] KIND_SYM   = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_POINTS = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;

  localparam logic [7:0] CH_POINT      = 8'h2E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_BQUOTE     = 8'h60;

  localparam int QUEUE_DEPTH = 4;

  // Token tracking state apart from the length counter.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] open_quote;
    logic       escape_pending;
    logic       point_seen;
    logic [7:0] pending_symbol;
    logic [7:0] token_start_char;
  } tok_t;

  localparam tok_t TOK_IDLE = '{mode: MODE_IDLE, open_quote: 8'd0, escape_pending: 1'b0,
                                point_seen: 1'b0, pending_symbol: 8'd0,
                                token_start_char: 8'd0};

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_length;
    logic [31:0] token_end_offset;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [1:0]  error_code;
    logic        last_of_run;
  } result_t;

  // Results produced by one byte, handed to the output queue.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    return (b == CH_DQUOTE) || (b == CH_SQUOTE) || (b == CH_BQUOTE);
  endfunction

  function automatic logic is_symbol(input logic [7:0] b);
    logic hit;
    case (b)
      8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h2E, 8'h3A, 8'h3C, 8'h3E, 8'h21, 8'h28,
      8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h2C, 8'h3B, 8'h26, 8'h7C, 8'h5E,
      8'h23: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    logic hit;
    case ({a, b})
      16'h3E3D, 16'h3C3D, 16'h213D, 16'h2B2B, 16'h2D2D, 16'h3D3D,
      16'h2D3E, 16'h3C2D, 16'h2626, 16'h7C7C, 16'h5E5E: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic result_t mk_result(input logic [2:0] kind, input logic [15:0] len,
                                        input logic [31:0] end_off, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [1:0] err);
    result_t r;
    r.token_kind       = kind;
    r.token_length     = len;
    r.token_end_offset = end_off;
    r.first_char       = c1;
    r.second_char      = c2;
    r.error_code       = err;
    r.last_of_run      = 1'b0;
    return r;
  endfunction

endpackage

// File: hw/rtl/stl_in_if.sv
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// File: hw/rtl/stl_out_if.sv
interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_length;
  logic [31:0] token_end_offset;
  logic [7:0]  first_char;
  logic [7:0]  second_char;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output token_end_offset, output first_char, output second_char,
                  output error_code, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_length,
                input token_end_offset, input first_char, input second_char,
                input error_code, input last_of_run, output ready);
endinterface

// File: hw/rtl/source_token_lexer.sv
// Streaming lexer: one source byte per transaction in, one token per transaction out.
// Numbers, identifiers, quoted strings (double, single or back quote, backslash escapes,
// quotes counted) and one- or two-byte symbols are recognized; any other byte closes the
// open token and is skipped. A second decimal point or a string still open at the
// end-of-text byte gives an error token, after which bytes are dropped up to end of text.
// The byte offset restarts at zero after each end-of-text byte. A byte is taken every
// cycle while the output queue has room: it is held in an input register, then the
// decode logic advances the token state and its results (zero, one or two) enter a
// four-entry output queue. A byte that closes two tokens gives two output transactions;
// the input stalls only while the queue
// holds more than two results, so the output port sets the rate when the text is dense
// in short tokens.
module source_token_lexer #(
  parameter int LENGTH_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  stl_in_if.sink    in_ch,
  stl_out_if.source out_ch
);

  `include "assert_macros.svh"

  stl_pkg::push_t push;
  logic [2:0]     queue_count;

  // Decode the held byte and advance the token state.
  stl_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .queue_count(queue_count),
    .push       (push)
  );

  // Hold results until the consumer takes each transaction.
  stl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .count (queue_count),
    .out_ch(out_ch)
  );

  `ASSERT_ALWAYS(a_queue_bound, clk, rst || (queue_count <= 3'(stl_pkg::QUEUE_DEPTH)), "queue overflow")
  `ASSERT_PROP(a_push_room, clk, rst, (push.num == 2'd0) || (queue_count <= 3'd2), "push without room")
  `ASSERT_PROP(a_err_code, clk, rst, out_ch.valid |-> ((out_ch.token_kind == stl_pkg::KIND_ERR) == (out_ch.error_code != stl_pkg::ERR_NONE)), "error code mismatch")
  `ASSERT_PROP(a_second_char, clk, rst, (out_ch.valid && out_ch.token_kind != stl_pkg::KIND_SYM) |-> (out_ch.second_char == 8'd0), "stray second char")

endmodule

// File: hw/rtl/stl_core.sv
module stl_core #(
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  stl_in_if.sink             in_ch,
  input  logic [2:0]         queue_count,
  output stl_pkg::push_t     push
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);

  logic                   hold_valid;
  logic [7:0]             hold_byte;
  logic                   hold_eot;
  logic                   fire;

  stl_pkg::tok_t          tok, tok_next;
  logic [LENGTH_BITS-1:0] length_count, len_next;
  logic [31:0]            byte_position, pos_next, pos_inc;

  logic                   consumed;
  logic                   a_valid, b_valid;
  stl_pkg::result_t       res_a, res_b;

  function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + LEN_ONE;
  endfunction

  function automatic logic [15:0] to_len16(input logic [LENGTH_BITS-1:0] v);
    return 16'(32'(v));
  endfunction

  // Step the held byte once the queue can take two results.
  assign fire        = hold_valid && (queue_count <= 3'(stl_pkg::QUEUE_DEPTH - 2));
  assign in_ch.ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      hold_byte <= in_ch.in_byte;
      hold_eot  <= in_ch.end_of_text;
    end
  end

  always_comb begin
    tok_next = tok;
    len_next = length_count;
    consumed = 1'b0;
    a_valid  = 1'b0;
    b_valid  = 1'b0;
    res_a    = '0;
    res_b    = '0;
    pos_inc  = byte_position + 32'd1;

    case (tok.mode)
      stl_pkg::MODE_DROP: begin
        consumed = 1'b1;
      end
      stl_pkg::MODE_NUM: begin
        if (stl_pkg::is_digit(hold_byte)) begin
          len_next = sat_inc(length_count);
          consumed = 1'b1;
        end else if (hold_byte == stl_pkg::CH_POINT) begin
          if (tok.point_seen) begin
            a_valid = 1'b1;
            res_a = stl_pkg::mk_result(stl_pkg::KIND_ERR, to_len16(sat_inc(length_count)),
                                       pos_inc, tok.token_start_char, 8'd0,
                                       stl_pkg::ERR_POINTS);
            tok_next      = stl_pkg::TOK_IDLE;
            len_next      = '0;
            tok_next.mode = stl_pkg::MODE_DROP;
          end else begin
            tok_next.point_seen = 1'b1;
            len_next = sat_inc(length_count);
          end
          consumed = 1'b1;
        end else begin
          a_valid = 1'b1;
          res_a = stl_pkg::mk_result(stl_pkg::KIND_NUM, to_len16(length_count), byte_position,
                                     tok.token_start_char, 8'd0, stl_pkg::ERR_NONE);
          tok_next = stl_pkg::TOK_IDLE;
          len_next = '0;
        end
      end
      stl_pkg::MODE_IDENT: begin
        if (stl_pkg::is_letter(hold_byte) || stl_pkg::is_digit(hold_byte) ||
            hold_byte == stl_pkg::CH_UNDERSCORE) begin
          len_next = sat_inc(length_count);
          consumed = 1'b1;
        end else begin
          a_valid = 1'b1;
          res_a = stl_pkg::mk_result(stl_pkg::KIND_IDENT, to_len16(length_count),
                                     byte_position, tok.token_start_char, 8'd0,
                                     stl_pkg::ERR_NONE);
          tok_next = stl_pkg::TOK_IDLE;
          len_next = '0;
        end
      end
      stl_pkg::MODE_STR: begin
        len_next = sat_inc(length_count);
        if (hold_byte == tok.open_quote && !tok.escape_pending) begin
          a_valid = 1'b1;
          res_a = stl_pkg::mk_result(stl_pkg::KIND_STR, to_len16(len_next), pos_inc,
                                     tok.open_quote, 8'd0, stl_pkg::ERR_NONE);
          tok_next = stl_pkg::TOK_IDLE;
          len_next = '0;
        end else begin
          tok_next.escape_pending = (hold_byte == stl_pkg::CH_BACKSLASH) &&
                                    !tok.escape_pending;
        end
        consumed = 1'b1;
      end
      stl_pkg::MODE_SYM: begin
        a_valid = 1'b1;
        if (stl_pkg::is_symbol(hold_byte) && stl_pkg::is_pair(tok.pending_symbol, hold_byte))
        begin
          res_a = stl_pkg::mk_result(stl_pkg::KIND_SYM, to_len16(LEN_TWO), pos_inc,
                                     tok.pending_symbol, hold_byte, stl_pkg::ERR_NONE);
          consumed = 1'b1;
        end else begin
          res_a = stl_pkg::mk_result(stl_pkg::KIND_SYM, to_len16(LEN_ONE), byte_position,
                                     tok.pending_symbol, 8'd0, stl_pkg::ERR_NONE);
        end
        tok_next = stl_pkg::TOK_IDLE;
        len_next = '0;
      end
      default: begin
        tok_next = stl_pkg::TOK_IDLE;
        len_next = '0;
      end
    endcase

    // Handle the byte afresh: it may open a new token.
    if (!consumed) begin
      if (stl_pkg::is_digit(hold_byte)) begin
        tok_next.mode             = stl_pkg::MODE_NUM;
        tok_next.token_start_char = hold_byte;
        len_next                  = LEN_ONE;
      end else if (stl_pkg::is_letter(hold_byte)) begin
        tok_next.mode             = stl_pkg::MODE_IDENT;
        tok_next.token_start_char = hold_byte;
        len_next                  = LEN_ONE;
      end else if (stl_pkg::is_quote(hold_byte)) begin
        tok_next.mode             = stl_pkg::MODE_STR;
        tok_next.open_quote       = hold_byte;
        tok_next.token_start_char = hold_byte;
        tok_next.escape_pending   = 1'b0;
        len_next                  = LEN_ONE;
      end else if (stl_pkg::is_symbol(hold_byte)) begin
        tok_next.mode           = stl_pkg::MODE_SYM;
        tok_next.pending_symbol = hold_byte;
        len_next                = LEN_ONE;
      end
    end

    // Flush whatever is open at the end of the text.
    if (hold_eot) begin
      case (tok_next.mode)
        stl_pkg::MODE_NUM: begin
          b_valid = 1'b1;
          res_b = stl_pkg::mk_result(stl_pkg::KIND_NUM, to_len16(len_next), pos_inc,
                                     tok_next.token_start_char, 8'd0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_IDENT: begin
          b_valid = 1'b1;
          res_b = stl_pkg::mk_result(stl_pkg::KIND_IDENT, to_len16(len_next), pos_inc,
                                     tok_next.token_start_char, 8'd0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_STR: begin
          b_valid = 1'b1;
          res_b = stl_pkg::mk_result(stl_pkg::KIND_ERR, to_len16(len_next), pos_inc,
                                     tok_next.open_quote, 8'd0, stl_pkg::ERR_UNTERM);
        end
        stl_pkg::MODE_SYM: begin
          b_valid = 1'b1;
          res_b = stl_pkg::mk_result(stl_pkg::KIND_SYM, to_len16(LEN_ONE), pos_inc,
                                     tok_next.pending_symbol, 8'd0, stl_pkg::ERR_NONE);
        end
        default: begin
        end
      endcase
      tok_next = stl_pkg::TOK_IDLE;
      len_next = '0;
      pos_next = 32'd0;
    end else begin
      pos_next = pos_inc;
    end
  end

  // Pack the results in order and mark the last one of the run.
  always_comb begin
    push.num = fire ? ({1'b0, a_valid} + {1'b0, b_valid}) : 2'd0;
    push.first  = a_valid ? res_a : res_b;
    push.second = res_b;
    push.first.last_of_run  = !(a_valid && b_valid);
    push.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok           <= stl_pkg::TOK_IDLE;
      length_count  <= '0;
      byte_position <= 32'd0;
    end else if (fire) begin
      tok           <= tok_next;
      length_count  <= len_next;
      byte_position <= pos_next;
    end
  end

endmodule

// File: hw/rtl/stl_queue.sv
module stl_queue (
  input  logic           clk,
  input  logic           rst,
  input  stl_pkg::push_t push,
  output logic [2:0]     count,
  stl_out_if.source      out_ch
);

  localparam int PTR_BITS = $clog2(stl_pkg::QUEUE_DEPTH);

  stl_pkg::result_t      entries [stl_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   head, tail;
  logic                  pop;
  stl_pkg::result_t      head_entry;

  assign pop        = out_ch.valid && out_ch.ready;
  assign head_entry = entries[head];

  assign out_ch.valid            = (count != 3'd0);
  assign out_ch.token_kind       = head_entry.token_kind;
  assign out_ch.token_length     = head_entry.token_length;
  assign out_ch.token_end_offset = head_entry.token_end_offset;
  assign out_ch.first_char       = head_entry.first_char;
  assign out_ch.second_char      = head_entry.second_char;
  assign out_ch.error_code       = head_entry.error_code;
  assign out_ch.last_of_run      = head_entry.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= 3'd0;
    end else begin
      head  <= head + PTR_BITS'(pop);
      tail  <= tail + PTR_BITS'(push.num);
      count <= count + 3'(push.num) - 3'(pop);
    end
    if (push.num != 2'd0) begin
      entries[tail] <= push.first;
    end
    if (push.num == 2'd2) begin
      entries[tail + PTR_BITS'(1)] <= push.second;
    end
  end

endmodule
